[rtl/core/hrsp_pkg.sv]
// ============================================================================
// hrsp_pkg: shared types and constants for the HTTP request stream parser
// Holds phase, length-scan and kind codes, the header key and the
// transaction payload types.
// ============================================================================
`default_nettype none

package hrsp_pkg;

    localparam int METHOD_MAX = 7;
    localparam int PATH_MAX   = 255;
    localparam int QUERY_MAX  = 511;
    localparam int BODY_CAP   = 4096;
    localparam int KEY_LEN    = 15;

    localparam int CNT_W  = 9;
    localparam int BCNT_W = 12;

    localparam logic [31:0] BODY_KEEP = 32'(BODY_CAP - 1);

    typedef enum logic [2:0] {
        PH_METHOD   = 3'd0,
        PH_GAP      = 3'd1,
        PH_PATH     = 3'd2,
        PH_PATH_END = 3'd3,
        PH_QUERY    = 3'd4,
        PH_REST     = 3'd5,
        PH_BODY     = 3'd6,
        PH_DONE     = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        LS_SEARCH   = 2'd0,
        LS_SPACES   = 2'd1,
        LS_DIGITS   = 2'd2,
        LS_FINISHED = 2'd3
    } lstage_t;

    localparam logic [2:0] KIND_METHOD = 3'd0;
    localparam logic [2:0] KIND_PATH   = 3'd1;
    localparam logic [2:0] KIND_QUERY  = 3'd2;
    localparam logic [2:0] KIND_BODY   = 3'd3;
    localparam logic [2:0] KIND_EVENT  = 3'd4;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_QM = 8'h3F;
    localparam logic [7:0] CH_PL = 8'h2B;
    localparam logic [7:0] CH_MI = 8'h2D;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            4'd0:  c = "c";
            4'd1:  c = "o";
            4'd2:  c = "n";
            4'd3:  c = "t";
            4'd4:  c = "e";
            4'd5:  c = "n";
            4'd6:  c = "t";
            4'd7:  c = "-";
            4'd8:  c = "l";
            4'd9:  c = "e";
            4'd10: c = "n";
            4'd11: c = "g";
            4'd12: c = "t";
            4'd13: c = "h";
            4'd14: c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic [7:0] data_in;
        logic       first;
    } in_item_t;

    // front-to-back queue entry: byte, restart and the tag decided in front
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       body;     // byte lands in the body phase
        logic       hdr_end;  // byte completes CR LF CR LF
        logic       req_tag;  // request-line byte with a tag
        logic [2:0] kind;
    } cls_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        headers_done;
        logic        complete;
        logic [31:0] decl_length;
        logic [11:0] body_count;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/core/hrsp_stream_if.sv]
// ============================================================================
// hrsp_stream_if: valid/ready channel
// Carries one payload per transaction.
// ============================================================================
`default_nettype none

interface hrsp_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/http_request_stream_parser.sv]
// ============================================================================
// http_request_stream_parser: streaming HTTP request byte parser
// Front classifier, two-entry queue, back length/body unit with result register.
// ============================================================================
// Path: a tagged byte accepted by the front is written into the queue, and
//   loads the result register when the back takes it from the queue.
// Throughput: one byte per cycle while the queue has room; front and back state
//   each update once per accepted byte; the queue absorbs output stalls.
// Reset: rst_n clears all parser state asynchronously to the method phase;
//   a byte with first set clears it as well before being handled.
`default_nettype none

module http_request_stream_parser (
    input wire logic clk,
    input wire logic rst_n,
    hrsp_stream_if.sink   in_ch,
    hrsp_stream_if.source out_ch
);
    import hrsp_pkg::*;

    // front -> queue
    logic fq_valid, fq_ready;
    cls_t fq_item;
    // queue -> back
    logic qb_valid, qb_ready;
    cls_t qb_item;

    // front tracks request line and header end per byte
    hrsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_item   (in_ch.payload),
        .in_ready  (in_ch.ready),
        .cls_valid (fq_valid),
        .cls_item  (fq_item),
        .cls_ready (fq_ready)
    );

    // short queue so front keeps accepting while the output is stalled
    hrsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_item  (fq_item),
        .wr_ready (fq_ready),
        .rd_valid (qb_valid),
        .rd_item  (qb_item),
        .rd_ready (qb_ready)
    );

    // back does the header length scan, body count and result transaction
    hrsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (qb_valid),
        .cls_item  (qb_item),
        .cls_ready (qb_ready),
        .out_valid (out_ch.valid),
        .out_item  (out_ch.payload),
        .out_ready (out_ch.ready)
    );

endmodule

`default_nettype wire

[rtl/core/hrsp_front.sv]
// ============================================================================
// hrsp_front: byte classifier
// Tracks the request line phase and the CRLFCRLF detector, tags each byte.
// ============================================================================
`default_nettype none

module hrsp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire hrsp_pkg::in_item_t   in_item,
    output logic                      in_ready,
    output logic                      cls_valid,
    output hrsp_pkg::cls_t            cls_item,
    input  wire logic                 cls_ready
);
    import hrsp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [23:0]       recent_reg, recent_next;
    logic              hdone_reg, hdone_next;

    phase_t            ph0;
    logic [CNT_W-1:0]  c0;
    logic [23:0]       r0;
    logic              hd0;
    logic [7:0]        b;
    logic              take;
    logic              is_tag;
    logic [2:0]        k;

    assign in_ready  = cls_ready;
    assign cls_valid = in_valid;
    assign take      = in_valid && cls_ready;
    assign b         = in_item.data_in;

    always_comb
    begin
        ph0 = in_item.first ? PH_METHOD : phase_reg;
        c0  = in_item.first ? '0 : cnt_reg;
        r0  = in_item.first ? '0 : recent_reg;
        hd0 = in_item.first ? 1'b0 : hdone_reg;
        phase_next  = ph0;
        cnt_next    = c0;
        recent_next = r0;
        hdone_next  = hd0;
        is_tag = 1'b0;
        k      = KIND_METHOD;
        cls_item = '0;
        cls_item.data  = b;
        cls_item.first = in_item.first;
        if (hd0)
        begin
            cls_item.body = 1'b1;
        end
        else if (r0 == {CH_CR, CH_LF, CH_CR} && b == CH_LF)
        begin
            cls_item.hdr_end = 1'b1;
            hdone_next  = 1'b1;
            recent_next = {r0[15:0], b};
        end
        else
        begin
            recent_next = {r0[15:0], b};
            unique case (ph0)
                PH_METHOD:
                begin
                    if (b == CH_SP)
                    begin
                        phase_next = PH_GAP;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        is_tag = 1'b1;
                        k      = KIND_METHOD;
                        if (c0 + 1'b1 >= CNT_W'(METHOD_MAX))
                        begin
                            phase_next = PH_GAP;
                            cnt_next   = '0;
                        end
                        else
                            cnt_next = c0 + 1'b1;
                    end
                end
                PH_GAP, PH_PATH:
                begin
                    if (ph0 == PH_GAP && b == CH_SP)
                    begin
                    end
                    else if (b == CH_SP || b == CH_CR)
                        phase_next = PH_REST;
                    else if (b == CH_QM)
                    begin
                        phase_next = PH_QUERY;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        is_tag = 1'b1;
                        k      = KIND_PATH;
                        cnt_next = (ph0 == PH_GAP) ? CNT_W'(1) : c0 + 1'b1;
                        phase_next = (cnt_next >= CNT_W'(PATH_MAX)) ? PH_PATH_END
                                                                     : PH_PATH;
                    end
                end
                PH_PATH_END:
                begin
                    if (b == CH_QM)
                    begin
                        phase_next = PH_QUERY;
                        cnt_next   = '0;
                    end
                    else
                        phase_next = PH_REST;
                end
                PH_QUERY:
                begin
                    if (b == CH_SP || b == CH_CR)
                        phase_next = PH_REST;
                    else
                    begin
                        is_tag   = 1'b1;
                        k        = KIND_QUERY;
                        cnt_next = c0 + 1'b1;
                        if (cnt_next >= CNT_W'(QUERY_MAX))
                            phase_next = PH_REST;
                    end
                end
                default:
                begin
                end
            endcase
        end
        cls_item.req_tag = is_tag;
        cls_item.kind    = k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_METHOD;
            cnt_reg    <= '0;
            recent_reg <= '0;
            hdone_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            recent_reg <= recent_next;
            hdone_reg  <= hdone_next;
        end
    end

`ifndef SYNTHESIS
    a_end_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && cls_item.hdr_end |=> hdone_reg)
        else $error("header end not recorded");
    a_no_tag_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        cls_item.body |-> !cls_item.req_tag)
        else $error("body byte tagged as request line");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUERY_MAX))
        else $error("field counter out of range");
`endif

endmodule

`default_nettype wire

[rtl/core/hrsp_queue.sv]
// ============================================================================
// hrsp_queue: two-entry queue between front and back
// Full-rate FIFO, registered outputs, cuts the ready path.
// ============================================================================
`default_nettype none

module hrsp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_valid,
    input  wire hrsp_pkg::cls_t  wr_item,
    output logic                 wr_ready,
    output logic                 rd_valid,
    output hrsp_pkg::cls_t       rd_item,
    input  wire logic            rd_ready
);
    import hrsp_pkg::*;

    cls_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rptr_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
                wptr_reg <= ~wptr_reg;
            if (rd)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == {1'b0, wptr_reg ^ rptr_reg} || cnt_reg == 2'd2)
        else $error("queue pointers inconsistent");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid && !rd_ready |=> rd_valid)
        else $error("queue lost an entry");
`endif

endmodule

`default_nettype wire

[rtl/core/hrsp_back.sv]
// ============================================================================
// hrsp_back: length scan, body accounting and result register
// Parses Content-Length, counts body bytes and builds result transactions.
// ============================================================================
`default_nettype none

module hrsp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cls_valid,
    input  wire hrsp_pkg::cls_t     cls_item,
    output logic                    cls_ready,
    output logic                    out_valid,
    output hrsp_pkg::out_item_t     out_item,
    input  wire logic               out_ready
);
    import hrsp_pkg::*;

    lstage_t     ls_reg, ls_next;
    logic [3:0]  mpos_reg, mpos_next;
    logic        lstart_reg, lstart_next;
    logic        neg_reg, neg_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rcv_reg, rcv_next;
    logic        done_reg, done_next;
    logic        hd_reg, hd_next;
    logic        ov_reg;
    out_item_t   out_reg;

    lstage_t     ls0;
    logic [3:0]  mp0;
    logic        lst0, ng0, dn0;
    logic [31:0] ln0, rc0, decl, dig;
    logic [7:0]  b, low;
    logic        isd, emit, take, keep;
    logic [2:0]  k;

    assign cls_ready = !ov_reg || out_ready;
    assign take      = cls_valid && cls_ready;
    assign out_valid = ov_reg;
    assign out_item  = out_reg;
    assign b   = cls_item.data;
    assign isd = (b >= "0") && (b <= "9");
    assign low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;

    function automatic logic [31:0] times_ten(input logic [31:0] v, input logic [3:0] d);
        logic [35:0] t;
        t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {32'd0, d};
        return (t[35:32] != 4'd0) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    always_comb
    begin
        ls0  = cls_item.first ? LS_SEARCH : ls_reg;
        mp0  = cls_item.first ? '0 : mpos_reg;
        lst0 = cls_item.first ? 1'b1 : lstart_reg;
        ng0  = cls_item.first ? 1'b0 : neg_reg;
        ln0  = cls_item.first ? '0 : len_reg;
        rc0  = cls_item.first ? '0 : rcv_reg;
        dn0  = cls_item.first ? 1'b0 : done_reg;
        dig  = 32'(b - "0");
        ls_next = ls0; mpos_next = mp0; lstart_next = lst0; neg_next = ng0;
        len_next = ln0; rcv_next = rc0; done_next = dn0;
        hd_next = cls_item.body || cls_item.hdr_end;
        decl = (ng0 && ln0 != 0) ? 32'hFFFF_FFFF : ln0;
        emit = 1'b0;
        keep = 1'b0;
        k    = cls_item.kind;
        if (cls_item.hdr_end)
        begin
            emit = 1'b1;
            k    = KIND_EVENT;
            done_next = (decl == 32'd0);
        end
        else if (cls_item.body)
        begin
            if (!dn0)
            begin
                rcv_next = rc0 + 32'd1;
                keep = (rcv_next <= BODY_KEEP);
                k = keep ? KIND_BODY : KIND_EVENT;
                emit = keep;
                if (rcv_next >= decl)
                begin
                    done_next = 1'b1;
                    emit = 1'b1;
                end
            end
        end
        else
        begin
            emit = cls_item.req_tag;
            unique case (ls0)
                LS_SEARCH:
                begin
                    if (mp0 != 0 || lst0)
                    begin
                        if (mp0 < 4'(KEY_LEN) && low == key_char(mp0))
                        begin
                            mpos_next = mp0 + 4'd1;
                            if (mpos_next == 4'(KEY_LEN))
                                ls_next = LS_SPACES;
                        end
                        else
                            mpos_next = '0;
                    end
                end
                LS_SPACES:
                begin
                    if (b != CH_SP)
                    begin
                        if (b == CH_PL || b == CH_MI)
                        begin
                            neg_next = (b == CH_MI);
                            ls_next  = LS_DIGITS;
                        end
                        else if (isd)
                        begin
                            len_next = times_ten(ln0, dig[3:0]);
                            ls_next  = LS_DIGITS;
                        end
                        else
                            ls_next = LS_FINISHED;
                    end
                end
                LS_DIGITS:
                begin
                    if (isd)
                        len_next = times_ten(ln0, dig[3:0]);
                    else
                        ls_next = LS_FINISHED;
                end
                default:
                begin
                end
            endcase
            lstart_next = (b == CH_LF);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ls_reg <= LS_SEARCH; mpos_reg <= '0; lstart_reg <= 1'b1; neg_reg <= 1'b0;
            len_reg <= '0; rcv_reg <= '0; done_reg <= 1'b0; hd_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ls_reg <= ls_next; mpos_reg <= mpos_next; lstart_reg <= lstart_next;
                neg_reg <= neg_next; len_reg <= len_next; rcv_reg <= rcv_next;
                done_reg <= done_next; hd_reg <= hd_next;
                ov_reg <= emit;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg.kind <= k;
            out_reg.data <= (k == KIND_EVENT) ? 8'h00 : b;
            out_reg.headers_done <= hd_next;
            out_reg.complete <= done_next;
            out_reg.decl_length <= (neg_next && len_next != 0) ? 32'hFFFF_FFFF
                                                               : len_next;
            out_reg.body_count <= (rcv_next < BODY_KEEP) ? rcv_next[BCNT_W-1:0]
                                                         : BODY_KEEP[BCNT_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_done_needs_hd: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> hd_reg)
        else $error("complete without headers");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_reg))
        else $error("result changed while stalled");
    a_mpos: assert property (@(posedge clk) disable iff (!rst_n)
        mpos_reg <= 4'(KEY_LEN))
        else $error("match position out of range");
`endif

endmodule

`default_nettype wire
